// File: hdl/rgle_pkg.sv
package rgle_pkg;

	localparam int COLOR_COUNT    = 7;
	localparam int SEG_W          = 3;
	localparam int BYTE_W         = 8;
	localparam int COLOR_W        = 24;
	localparam int CHAN_COUNT     = 3;
	localparam int CHAN_W         = 2;
	localparam int BITS_PER_FRAME = 24;
	localparam int BIT_CNT_W      = 5;
	localparam int SERIAL_CNT_W   = 3;
	localparam int CFG_IDX_W      = 4;
	localparam int UNITS_W        = 3;

	localparam logic [BYTE_W-1:0] STEPS_RESET = 8'd100;
	localparam logic [BYTE_W-1:0] STEPS_MIN   = 8'd1;
	localparam logic [BYTE_W-1:0] STEPS_MAX   = 8'd254;

	localparam logic [CFG_IDX_W-1:0] REG_STEPS       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_FIRST = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_LAST  = CFG_IDX_W'(COLOR_COUNT);

	localparam logic [UNITS_W-1:0] UNITS_LONG  = 3'd7;
	localparam logic [UNITS_W-1:0] UNITS_SHORT = 3'd1;

	localparam logic [COLOR_W-1:0] PALETTE_RESET [7] = '{
		24'hFF0000, 24'hFF7F00, 24'hFFFF00, 24'h00FF00,
		24'h00FFFF, 24'h0000FF, 24'h9400D3
	};

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] value;
	} chan_res_t;

	function automatic logic [SEG_W-1:0] next_seg(input logic [SEG_W-1:0] s);
		logic [SEG_W-1:0] r;
		if (s >= SEG_W'(COLOR_COUNT - 1)) begin
			r = '0;
		end else begin
			r = s + SEG_W'(1);
		end
		return r;
	endfunction

endpackage

// File: hdl/rgle_chan.sv
module rgle_chan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [rgle_pkg::BYTE_W-1:0]    first,
	input  logic [rgle_pkg::BYTE_W-1:0]    finish,
	input  logic [rgle_pkg::BYTE_W-1:0]    steps,
	input  logic [rgle_pkg::BYTE_W-1:0]    idx,
	output rgle_pkg::chan_res_t            res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DIV  = 2'd1;
	localparam logic [1:0] PH_MUL  = 2'd2;
	localparam logic [1:0] PH_FIN  = 2'd3;

	logic [1:0]                          phase_q;
	logic [rgle_pkg::SERIAL_CNT_W-1:0]   cnt_q;
	logic [rgle_pkg::BYTE_W-1:0]         a_q;
	logic [rgle_pkg::BYTE_W-1:0]         d_q;
	logic [rgle_pkg::BYTE_W-1:0]         rem_q;
	logic [rgle_pkg::BYTE_W-1:0]         quo_q;
	logic [rgle_pkg::BYTE_W-1:0]         idx_q;
	logic [rgle_pkg::BYTE_W-1:0]         prod_q;
	logic [rgle_pkg::BYTE_W-1:0]         base_q;
	logic                                neg_q;
	logic                                done_q;
	logic [rgle_pkg::BYTE_W-1:0]         value_q;

	logic [rgle_pkg::BYTE_W:0]           trial;
	logic [rgle_pkg::BYTE_W:0]           trial_sub;
	logic                                fits;
	logic                                last_cnt;

	assign trial     = {rem_q, a_q[rgle_pkg::BYTE_W-1]};
	assign trial_sub = trial - {1'b0, d_q};
	assign fits      = trial >= {1'b0, d_q};
	assign last_cnt  = cnt_q == '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (go) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_cnt) begin
						phase_q <= PH_MUL;
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_cnt) begin
						phase_q <= PH_FIN;
					end
				end
				PH_FIN: begin
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (go) begin
					neg_q  <= finish < first;
					a_q    <= (finish < first) ? (first - finish) : (finish - first);
					d_q    <= steps;
					rem_q  <= '0;
					quo_q  <= '0;
					idx_q  <= idx;
					prod_q <= '0;
					base_q <= first;
				end
			end
			PH_DIV: begin
				a_q   <= {a_q[rgle_pkg::BYTE_W-2:0], 1'b0};
				rem_q <= fits ? trial_sub[rgle_pkg::BYTE_W-1:0] : trial[rgle_pkg::BYTE_W-1:0];
				quo_q <= {quo_q[rgle_pkg::BYTE_W-2:0], fits};
			end
			PH_MUL: begin
				prod_q <= {prod_q[rgle_pkg::BYTE_W-2:0], 1'b0}
					+ (idx_q[rgle_pkg::BYTE_W-1] ? quo_q : '0);
				idx_q  <= {idx_q[rgle_pkg::BYTE_W-2:0], 1'b0};
			end
			PH_FIN: begin
				value_q <= neg_q ? (base_q - prod_q) : (base_q + prod_q);
			end
			default: begin
			end
		endcase
	end

	assign res.done  = done_q;
	assign res.value = value_q;

endmodule

// File: hdl/rgle_ser.sv
module rgle_ser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [rgle_pkg::COLOR_W-1:0]      color,
	output logic                              ready,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              data_bit,
	output logic [rgle_pkg::UNITS_W-1:0]      high_units,
	output logic [rgle_pkg::UNITS_W-1:0]      low_units,
	output logic                              frame_last
);

	logic                               busy_q;
	logic [rgle_pkg::COLOR_W-1:0]       sh_q;
	logic [rgle_pkg::BIT_CNT_W-1:0]     cnt_q;
	logic                               last_bit;

	assign last_bit = cnt_q == rgle_pkg::BIT_CNT_W'(rgle_pkg::BITS_PER_FRAME - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (!out_stall) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (load) begin
				sh_q <= color;
			end
		end else if (!out_stall) begin
			sh_q <= {sh_q[rgle_pkg::COLOR_W-2:0], 1'b0};
		end
	end

	assign ready      = !busy_q;
	assign out_valid  = busy_q;
	assign data_bit   = sh_q[rgle_pkg::COLOR_W-1];
	assign high_units = sh_q[rgle_pkg::COLOR_W-1] ? rgle_pkg::UNITS_LONG : rgle_pkg::UNITS_SHORT;
	assign low_units  = sh_q[rgle_pkg::COLOR_W-1] ? rgle_pkg::UNITS_SHORT : rgle_pkg::UNITS_LONG;
	assign frame_last = busy_q && last_bit;

endmodule

// File: hdl/rainbow_gradient_led_encoder_unit.sv
// An accepted frame request reads the segment's start and end colors, passes the
// three channels in turn through one bit-serial divide and multiply unit and loads
// the color into the serializer, which sends 24 bit symbols at one per cycle while
// the output is not stalled; the next request is taken once the serializer is loaded.
// Reset is asynchronous and active low; it loads the default palette and step count
// and restarts the fade at the first segment, step zero.
module rainbow_gradient_led_encoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                frame_tick,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                data_bit,
	output logic [rgle_pkg::UNITS_W-1:0]        high_units,
	output logic [rgle_pkg::UNITS_W-1:0]        low_units,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rgle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgle_pkg::COLOR_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDS  = 3'd1;
	localparam logic [2:0] ST_RDE  = 3'd2;
	localparam logic [2:0] ST_GO   = 3'd3;
	localparam logic [2:0] ST_CALC = 3'd4;
	localparam logic [2:0] ST_SEND = 3'd5;

	logic [2:0]                          state_q;
	logic [rgle_pkg::BYTE_W-1:0]         steps_q;
	logic [rgle_pkg::COLOR_W-1:0]        palette_q [rgle_pkg::COLOR_COUNT];
	logic [rgle_pkg::SEG_W-1:0]          seg_q;
	logic [rgle_pkg::BYTE_W-1:0]         step_q;
	logic [rgle_pkg::CHAN_W-1:0]         chan_q;
	logic [rgle_pkg::COLOR_W-1:0]        start_q;
	logic [rgle_pkg::COLOR_W-1:0]        end_q;
	logic [rgle_pkg::COLOR_W-1:0]        color_q;

	logic [rgle_pkg::BYTE_W-1:0]         steps_use;
	logic [rgle_pkg::SEG_W-1:0]          seg_safe;
	logic [rgle_pkg::SEG_W-1:0]          seg_rd;
	logic [rgle_pkg::COLOR_W-1:0]        pal_rd;
	logic [rgle_pkg::CFG_IDX_W-1:0]      pal_wr_idx;
	logic                                accept;
	logic                                chan_go;
	logic                                ser_ready;
	logic                                ser_load;
	rgle_pkg::chan_res_t                 chan_res;

	always_comb begin
		steps_use = steps_q;
		if (steps_q < rgle_pkg::STEPS_MIN) begin
			steps_use = rgle_pkg::STEPS_MIN;
		end else if (steps_q > rgle_pkg::STEPS_MAX) begin
			steps_use = rgle_pkg::STEPS_MAX;
		end
	end

	assign seg_safe   = (seg_q >= rgle_pkg::SEG_W'(rgle_pkg::COLOR_COUNT)) ? '0 : seg_q;
	assign seg_rd     = (state_q == ST_RDE) ? rgle_pkg::next_seg(seg_q) : seg_q;
	assign pal_rd     = palette_q[seg_rd];
	assign pal_wr_idx = cfg_index - rgle_pkg::REG_COLOR_FIRST;
	assign accept     = in_valid && !in_stall;
	assign in_stall   = state_q != ST_IDLE;
	assign cfg_ready  = 1'b1;
	assign chan_go    = state_q == ST_GO;
	assign ser_load   = (state_q == ST_SEND) && ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= rgle_pkg::STEPS_RESET;
			for (int k = 0; k < rgle_pkg::COLOR_COUNT; k++) begin
				palette_q[k] <= rgle_pkg::PALETTE_RESET[k];
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rgle_pkg::REG_STEPS) begin
				steps_q <= cfg_data[rgle_pkg::BYTE_W-1:0];
			end else if (cfg_index >= rgle_pkg::REG_COLOR_FIRST
				&& cfg_index <= rgle_pkg::REG_COLOR_LAST) begin
				palette_q[pal_wr_idx[rgle_pkg::SEG_W-1:0]] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= '0;
			step_q  <= '0;
			chan_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && frame_tick) begin
						state_q <= ST_RDS;
						chan_q  <= '0;
						if (step_q > steps_use) begin
							step_q <= '0;
							seg_q  <= rgle_pkg::next_seg(seg_safe);
						end else begin
							seg_q <= seg_safe;
						end
					end
				end
				ST_RDS: begin
					state_q <= ST_RDE;
				end
				ST_RDE: begin
					state_q <= ST_GO;
				end
				ST_GO: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (chan_res.done) begin
						chan_q <= chan_q + 1'b1;
						if (chan_q == rgle_pkg::CHAN_W'(rgle_pkg::CHAN_COUNT - 1)) begin
							state_q <= ST_SEND;
						end else begin
							state_q <= ST_GO;
						end
					end
				end
				ST_SEND: begin
					if (ser_ready) begin
						state_q <= ST_IDLE;
						if (step_q >= steps_use) begin
							step_q <= '0;
							seg_q  <= rgle_pkg::next_seg(seg_q);
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RDS: begin
				start_q <= pal_rd;
			end
			ST_RDE: begin
				end_q <= pal_rd;
			end
			ST_CALC: begin
				if (chan_res.done) begin
					color_q <= {color_q[rgle_pkg::COLOR_W-rgle_pkg::BYTE_W-1:0], chan_res.value};
					start_q <= {start_q[rgle_pkg::COLOR_W-rgle_pkg::BYTE_W-1:0],
						{rgle_pkg::BYTE_W{1'b0}}};
					end_q   <= {end_q[rgle_pkg::COLOR_W-rgle_pkg::BYTE_W-1:0],
						{rgle_pkg::BYTE_W{1'b0}}};
				end
			end
			default: begin
			end
		endcase
	end

	rgle_chan u_chan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (chan_go),
		.first  (start_q[rgle_pkg::COLOR_W-1 -: rgle_pkg::BYTE_W]),
		.finish (end_q[rgle_pkg::COLOR_W-1 -: rgle_pkg::BYTE_W]),
		.steps  (steps_use),
		.idx    (step_q),
		.res    (chan_res)
	);

	rgle_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (ser_load),
		.color      (color_q),
		.ready      (ser_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_bit   (data_bit),
		.high_units (high_units),
		.low_units  (low_units),
		.frame_last (frame_last)
	);

endmodule
